/* rtl/mqrp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqrp_pkg
// Shared types and constants of the multi-queue rank priority store.
// ============================================================================
package mqrp_pkg;

    // Default sizing, handed to the top level parameters.
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int NUM_LEVELS_DEF  = 5;

    // Fixed field widths of the channels.
    localparam int QUEUE_W = 3;
    localparam int ID_W    = 16;
    localparam int RANK_W  = 3;

    // Depth of the command queue between classifier and executor.
    localparam int CMD_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_ENTERED = 2'd0,
        ST_DROPPED = 2'd1,
        ST_SERVED  = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ENTER        = 2'd0,
        OP_SERVE        = 2'd1,
        OP_REJECT_ENTER = 2'd2,
        OP_REJECT_SERVE = 2'd3
    } t_op;

    // Classified item as it travels from the front end to the executor.
    typedef struct packed {
        t_op               op;
        logic [QUEUE_W-1:0] queue;
        logic [RANK_W-1:0]  rank;
        logic [ID_W-1:0]    client_id;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_META,
        BK_RESP
    } t_bk_state;

endpackage

/* rtl/mqrp_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqrp_req_if / mqrp_rsp_if
// Valid/ready channels for requests and results of the rank priority store.
// ============================================================================
interface mqrp_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [2:0]  queue_number;
    logic [15:0] client_id;
    logic [2:0]  rank_level;

    modport source (output valid, mode, queue_number, client_id, rank_level,
                    input ready);
    modport sink   (input valid, mode, queue_number, client_id, rank_level,
                    output ready);
endinterface

interface mqrp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [2:0]  served_rank;

    modport source (output valid, status, served_id, served_rank,
                    input ready);
    modport sink   (input valid, status, served_id, served_rank,
                    output ready);
endinterface

/* rtl/mqrp_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqrp_front
// Accepts request items and classifies them into executor commands.
// ============================================================================
module mqrp_front
    import mqrp_pkg::*;
#(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    mqrp_req_if.sink i_req,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_ready
);

    logic queue_ok;
    logic rank_ok;

    assign queue_ok = {29'd0, i_req.queue_number} < NUM_QUEUES;
    assign rank_ok  = {29'd0, i_req.rank_level} < NUM_LEVELS;

    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

    always_comb begin
        o_cmd.client_id = i_req.client_id;
        // Unknown rank codes fall back to the lowest rank.
        o_cmd.rank      = rank_ok ? i_req.rank_level : '0;
        // Rejected items carry queue zero so the executor never indexes past its state.
        o_cmd.queue     = queue_ok ? i_req.queue_number : '0;
        if (queue_ok) begin
            o_cmd.op = i_req.mode ? OP_SERVE : OP_ENTER;
        end else begin
            o_cmd.op = i_req.mode ? OP_REJECT_SERVE : OP_REJECT_ENTER;
        end
    end

endmodule

/* rtl/mqrp_cmd_fifo.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqrp_cmd_fifo
// Short command queue that decouples the classifier from the executor.
// ============================================================================
module mqrp_cmd_fifo
    import mqrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_ready
);

    localparam int DEPTH = CMD_FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_buf[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

/* rtl/mqrp_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqrp_back
// Executes commands against the level bookkeeping and the client store,
// and holds the result in an output register.
// ============================================================================
module mqrp_back
    import mqrp_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    mqrp_rsp_if.source o_rsp
);

    localparam int SLOTS       = NUM_QUEUES * NUM_LEVELS;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int LVL_W       = $clog2(NUM_LEVELS);
    localparam int HEAD_W      = $clog2(LEVEL_DEPTH);
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int STORE_DEPTH = SLOTS * LEVEL_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Level bookkeeping and client store.
    logic [HEAD_W-1:0] r_head_mem [SLOTS];
    logic [CNT_W-1:0]  r_cnt_mem  [SLOTS];
    logic [ID_W-1:0]   r_store    [STORE_DEPTH];

    // A slot whose bookkeeping was never written reads as empty with head zero.
    logic [SLOTS-1:0]  r_slot_vld;
    logic [SLOTS-1:0]  r_nonempty;

    t_bk_state         r_state, n_state;

    // Current command.
    logic [SLOT_W-1:0] r_slot;
    logic [ADDR_W-1:0] r_base;
    logic [LVL_W-1:0]  r_lvl;
    logic              r_is_serve;
    logic [ID_W-1:0]   r_id;
    t_status           r_status;

    logic [HEAD_W-1:0] r_head_rd;
    logic [CNT_W-1:0]  r_cnt_rd;
    logic              r_meta_ok;
    logic [ID_W-1:0]   r_store_rd;

    logic              r_out_vld;
    t_status           r_out_status;
    logic [ID_W-1:0]   r_out_id;
    logic [RANK_W-1:0] r_out_rank;

    // Dispatch decode.
    logic              out_free;
    logic              dispatch;
    logic              pop;
    logic              load_out;
    logic              d_found;
    logic [LVL_W-1:0]  d_top_lvl;
    logic [LVL_W-1:0]  d_lvl;
    logic [SLOT_W-1:0] d_slot;
    logic              d_go_meta;
    t_status           d_status;

    // Bookkeeping update.
    logic              in_meta;
    logic [HEAD_W-1:0] cur_head;
    logic [CNT_W-1:0]  cur_cnt;
    logic              lvl_full;
    logic [HEAD_W:0]   tail_sum;
    logic [HEAD_W-1:0] tail_pos;
    logic [HEAD_W-1:0] head_next;
    logic              meta_wr;
    logic [HEAD_W-1:0] meta_head_wr;
    logic [CNT_W-1:0]  meta_cnt_wr;
    logic              store_wr;
    logic [ADDR_W-1:0] store_addr;

    assign out_free = !r_out_vld || o_rsp.ready;
    assign pop      = i_cmd_valid && o_cmd_ready;

    // FSM outputs.
    always_comb begin
        dispatch = 1'b0;
        load_out = 1'b0;
        in_meta  = 1'b0;
        unique case (r_state)
            BK_IDLE: dispatch = 1'b1;
            BK_META: in_meta  = 1'b1;
            BK_RESP: begin
                load_out = out_free;
                dispatch = out_free;
            end
            default: ;
        endcase
    end

    assign o_cmd_ready = dispatch;

    // Highest non-empty level of the addressed queue.
    always_comb begin
        d_found   = 1'b0;
        d_top_lvl = '0;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            if (r_nonempty[SLOT_W'(int'(i_cmd.queue) * NUM_LEVELS + lv)]) begin
                d_found   = 1'b1;
                d_top_lvl = LVL_W'(lv);
            end
        end
    end

    always_comb begin
        d_lvl     = (i_cmd.op == OP_SERVE) ? d_top_lvl : LVL_W'(i_cmd.rank);
        d_slot    = SLOT_W'(int'(i_cmd.queue) * NUM_LEVELS + int'(d_lvl));
        d_go_meta = (i_cmd.op == OP_ENTER) || ((i_cmd.op == OP_SERVE) && d_found);
        d_status  = (i_cmd.op == OP_REJECT_ENTER) ? ST_DROPPED : ST_EMPTY;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = d_go_meta ? BK_META : BK_RESP;
                end
            end
            BK_META: n_state = BK_RESP;
            BK_RESP: begin
                if (out_free) begin
                    if (i_cmd_valid) begin
                        n_state = d_go_meta ? BK_META : BK_RESP;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Bookkeeping arithmetic for the level in hand.
    always_comb begin
        cur_head  = r_meta_ok ? r_head_rd : '0;
        cur_cnt   = r_meta_ok ? r_cnt_rd : '0;
        lvl_full  = cur_cnt == CNT_W'(LEVEL_DEPTH);
        tail_sum  = {1'b0, cur_head} + (HEAD_W + 1)'(cur_cnt);
        if (tail_sum >= (HEAD_W + 1)'(LEVEL_DEPTH)) begin
            tail_pos = HEAD_W'(tail_sum - (HEAD_W + 1)'(LEVEL_DEPTH));
        end else begin
            tail_pos = HEAD_W'(tail_sum);
        end
        head_next = (cur_head == HEAD_W'(LEVEL_DEPTH - 1)) ? '0 : cur_head + 1'b1;

        store_wr     = in_meta && !r_is_serve && !lvl_full;
        meta_wr      = in_meta && (r_is_serve || !lvl_full);
        meta_head_wr = r_is_serve ? head_next : cur_head;
        meta_cnt_wr  = r_is_serve ? cur_cnt - 1'b1 : cur_cnt + 1'b1;
        store_addr   = r_base + ADDR_W'(r_is_serve ? cur_head : tail_pos);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_slot_vld <= '0;
            r_nonempty <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (meta_wr) begin
                r_slot_vld[r_slot] <= 1'b1;
                r_nonempty[r_slot] <= (meta_cnt_wr != '0);
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Command and result payload.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_slot     <= d_slot;
            r_base     <= ADDR_W'(int'(d_slot) * LEVEL_DEPTH);
            r_lvl      <= d_lvl;
            r_is_serve <= i_cmd.op == OP_SERVE;
            r_id       <= i_cmd.client_id;
            r_status   <= d_status;
            r_meta_ok  <= r_slot_vld[d_slot];
        end else if (in_meta) begin
            if (r_is_serve) begin
                r_status <= ST_SERVED;
            end else begin
                r_status <= lvl_full ? ST_DROPPED : ST_ENTERED;
            end
        end
        if (load_out) begin
            r_out_status <= r_status;
            r_out_id     <= (r_status == ST_SERVED) ? r_store_rd : '0;
            r_out_rank   <= (r_status == ST_SERVED) ? RANK_W'(r_lvl) : '0;
        end
    end

    // Bookkeeping memory: read on dispatch, written back in the BK_META state that follows.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head_rd <= r_head_mem[d_slot];
            r_cnt_rd  <= r_cnt_mem[d_slot];
        end
        if (meta_wr) begin
            r_head_mem[r_slot] <= meta_head_wr;
            r_cnt_mem[r_slot]  <= meta_cnt_wr;
        end
    end

    // Client store: at most one write or one read per item.
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[store_addr] <= r_id;
        end
        if (in_meta && r_is_serve) begin
            r_store_rd <= r_store[store_addr];
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.served_id   = r_out_id;
    assign o_rsp.served_rank = r_out_rank;

endmodule

/* rtl/multi_queue_rank_priority.sv */
`timescale 1ns / 1ps
// ============================================================================
// multi_queue_rank_priority
// Set of rank-ordered client queues with arrival order kept within a rank.
// ============================================================================
// Usage:
// i_req carries one item per handshake: mode 0 enters client_id into queue
// queue_number at rank_level, mode 1 serves the oldest client of the highest
// non-empty rank of that queue. o_rsp returns exactly one result per item, in
// item order: entered, dropped (level full or no such queue), served with the
// client and its rank, or queue empty.
// Items that enter or serve a client read the level's head and count on
// dispatch, write them back in the BK_META state and reach the output register
// from BK_RESP; rejected items and serves of an empty queue touch no level and
// go straight to BK_RESP. The executor takes no new item in BK_META, and takes
// the next one in BK_RESP in the same cycle as a result enters the output register.
// A two-entry command queue keeps taking items while a result waits in the
// output register; when o_rsp stalls, work stops after that queue fills and
// i_req.ready drops.
// Reset empties every queue at once; the client store is not cleared.
// ============================================================================
module multi_queue_rank_priority
    import mqrp_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqrp_req_if.sink   i_req,
    mqrp_rsp_if.source o_rsp
);

    logic front_valid;
    t_cmd front_cmd;
    logic front_ready;
    logic exec_valid;
    t_cmd exec_cmd;
    logic exec_ready;

    mqrp_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    mqrp_cmd_fifo u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (exec_valid),
        .o_pop_cmd    (exec_cmd),
        .i_pop_ready  (exec_ready)
    );

    mqrp_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (exec_valid),
        .i_cmd       (exec_cmd),
        .o_cmd_ready (exec_ready),
        .o_rsp       (o_rsp)
    );

endmodule

/* rtl/mqrp_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqrp_checker
// Port-level checks on the result channel of the rank priority store.
// ============================================================================
module mqrp_checker
    import mqrp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [15:0] i_rsp_served_id,
    input logic [2:0]  i_rsp_served_rank
);

    // A result stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result withdrawn before it was taken");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_status) && $stable(i_rsp_served_id)
            && $stable(i_rsp_served_rank))
        else $error("stalled result changed");

    // Only a served result carries a client and a rank.
    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_SERVED) |->
            (i_rsp_served_id == '0) && (i_rsp_served_rank == '0))
        else $error("non-served result carries client data");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result pending after reset");

endmodule

bind multi_queue_rank_priority mqrp_checker u_mqrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_served_id   (o_rsp.served_id),
    .i_rsp_served_rank (o_rsp.served_rank)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the multi-queue rank priority store. Items go in
// through the request channel, and every result is compared with a local
// model of the rank levels. Directed cases come first, then randomized
// traffic with and without idling on both channels.
// ============================================================================
module testbench;
    import mqrp_pkg::*;

    localparam int SLOTS          = NUM_QUEUES_DEF * NUM_LEVELS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 10;

    localparam bit MODE_ENTER = 1'b0;
    localparam bit MODE_SERVE = 1'b1;

    localparam logic [RANK_W-1:0] RANK_UNKNOWN  = 3'd0;
    localparam logic [RANK_W-1:0] RANK_SOLDIER  = 3'd1;
    localparam logic [RANK_W-1:0] RANK_SERGEANT = 3'd2;
    localparam logic [RANK_W-1:0] RANK_CAPTAIN  = 3'd3;
    localparam logic [RANK_W-1:0] RANK_COLONEL  = 3'd4;

    typedef struct {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [RANK_W-1:0]  rank;
    } t_served_result;

    logic i_clk;
    logic i_rst_n;

    mqrp_req_if req_ch ();
    mqrp_rsp_if rsp_ch ();

    multi_queue_rank_priority uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Local copy of the rank levels: head, fill count and ring contents.
    int              lvl_head  [SLOTS];
    int              lvl_count [SLOTS];
    logic [ID_W-1:0] lvl_ids   [SLOTS * LEVEL_DEPTH_DEF];

    t_served_result pending_results[$];

    bit sender_gaps;
    bit sink_stalls;
    int stall_left;
    int fail_count;
    int items_sent;
    int status_seen [4];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_served_result predict_rank_queue(bit mode, logic [QUEUE_W-1:0] q,
                                                         logic [ID_W-1:0] id,
                                                         logic [RANK_W-1:0] rank);
        t_served_result res;
        int lvl;
        int slot;
        int pos;
        res.status = ST_ENTERED;
        res.id     = '0;
        res.rank   = '0;
        if (q >= NUM_QUEUES_DEF) begin
            if (mode == MODE_SERVE) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_DROPPED;
            end
            return res;
        end
        if (mode == MODE_ENTER) begin
            // Rank codes past the top level fall back to unknown.
            lvl  = (rank >= NUM_LEVELS_DEF) ? int'(RANK_UNKNOWN) : int'(rank);
            slot = q * NUM_LEVELS_DEF + lvl;
            if (lvl_count[slot] >= LEVEL_DEPTH_DEF) begin
                res.status = ST_DROPPED;
            end else begin
                pos = (lvl_head[slot] + lvl_count[slot]) % LEVEL_DEPTH_DEF;
                lvl_ids[slot * LEVEL_DEPTH_DEF + pos] = id;
                lvl_count[slot]++;
            end
            return res;
        end
        res.status = ST_EMPTY;
        for (lvl = NUM_LEVELS_DEF - 1; lvl >= 0; lvl--) begin
            slot = q * NUM_LEVELS_DEF + lvl;
            if (lvl_count[slot] != 0) begin
                res.status = ST_SERVED;
                res.id     = lvl_ids[slot * LEVEL_DEPTH_DEF + lvl_head[slot]];
                res.rank   = lvl[RANK_W-1:0];
                lvl_head[slot] = (lvl_head[slot] + 1) % LEVEL_DEPTH_DEF;
                lvl_count[slot]--;
                return res;
            end
        end
        return res;
    endfunction

    task automatic send_item(bit mode, logic [QUEUE_W-1:0] q, logic [ID_W-1:0] id,
                             logic [RANK_W-1:0] rank);
        int gap;
        gap = sender_gaps ? random_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.queue_number <= q;
        req_ch.client_id    <= id;
        req_ch.rank_level   <= rank;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_results.insert(pending_results.size(), predict_rank_queue(mode, q, id, rank));
        items_sent++;
    endtask

    // Holds the request channel quiet until every pending result is back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        send_item(MODE_SERVE, 3'd0, 16'hBEEF, 3'd7);
        send_item(MODE_ENTER, 3'd0, 16'hFFFF, RANK_COLONEL);
        send_item(MODE_ENTER, 3'd0, 16'h0000, RANK_UNKNOWN);
        send_item(MODE_ENTER, 3'd0, 16'h1234, RANK_SOLDIER);
        send_item(MODE_ENTER, 3'd0, 16'hA5A5, RANK_SERGEANT);
        send_item(MODE_ENTER, 3'd0, 16'h5A5A, RANK_CAPTAIN);
        send_item(MODE_ENTER, 3'd0, 16'h0001, RANK_CAPTAIN);
        // Codes above colonel land in the unknown level, in arrival order.
        send_item(MODE_ENTER, 3'd7, 16'h8000, 3'd5);
        send_item(MODE_ENTER, 3'd7, 16'h7FFF, 3'd6);
        send_item(MODE_ENTER, 3'd7, 16'h00FF, 3'd7);
        send_item(MODE_ENTER, 3'd7, 16'hFF00, RANK_UNKNOWN);
        repeat (7) send_item(MODE_SERVE, 3'd0, 16'($urandom), 3'($urandom));
        repeat (5) send_item(MODE_SERVE, 3'd7, 16'($urandom), 3'($urandom));
    endtask

    task automatic test_level_full();
        logic [QUEUE_W-1:0] q;
        logic [RANK_W-1:0]  rank;
        q    = 3'($urandom_range(0, NUM_QUEUES_DEF - 1));
        rank = 3'($urandom_range(0, NUM_LEVELS_DEF - 1));
        repeat (LEVEL_DEPTH_DEF) send_item(MODE_ENTER, q, 16'($urandom), rank);
        send_item(MODE_ENTER, q, 16'($urandom), rank);
        repeat (LEVEL_DEPTH_DEF + 1) send_item(MODE_SERVE, q, 16'($urandom), 3'($urandom));
    endtask

    // Traffic on hot_queues queues from a random base so that levels fill, wrap and drain.
    task automatic test_random_traffic(int n_items, int enter_pct, int hot_queues);
        int base;
        logic [RANK_W-1:0] rank;
        logic [QUEUE_W-1:0] q;
        base = $urandom_range(0, NUM_QUEUES_DEF - 1);
        repeat (n_items) begin
            q = 3'((base + $urandom_range(0, hot_queues - 1)) % NUM_QUEUES_DEF);
            if ($urandom_range(0, 9) < 8) begin
                rank = 3'($urandom_range(0, NUM_LEVELS_DEF - 1));
            end else begin
                rank = 3'($urandom_range(NUM_LEVELS_DEF, 7));
            end
            if ($urandom_range(0, 99) < enter_pct) begin
                send_item(MODE_ENTER, q, 16'($urandom), rank);
            end else begin
                send_item(MODE_SERVE, q, 16'($urandom), rank);
            end
        end
    endtask

    task automatic check_result();
        t_served_result exp;
        if (pending_results.size() == 0) begin
            $error("result with no item pending: status %0d, served_id %0d, served_rank %0d",
                   rsp_ch.status, rsp_ch.served_id, rsp_ch.served_rank);
            fail_count++;
            return;
        end
        exp = pending_results.pop_front();
        status_seen[exp.status]++;
        if (rsp_ch.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, rsp_ch.status);
            fail_count++;
        end
        if (rsp_ch.served_id !== exp.id) begin
            $error("served_id: expected %0d, actual %0d", exp.id, rsp_ch.served_id);
            fail_count++;
        end
        if (rsp_ch.served_rank !== exp.rank) begin
            $error("served_rank: expected %0d, actual %0d", exp.rank, rsp_ch.served_rank);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                check_result();
            end
            if (sink_stalls && stall_left == 0 && $urandom_range(0, 4) == 0) begin
                stall_left = random_gap();
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        foreach (lvl_head[i]) begin
            lvl_head[i]  = 0;
            lvl_count[i] = 0;
        end
        fail_count  = 0;
        items_sent  = 0;
        status_seen = '{0, 0, 0, 0};
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_ENTER;
        req_ch.queue_number <= '0;
        req_ch.client_id    <= '0;
        req_ch.rank_level   <= RANK_UNKNOWN;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_for_results();
        test_level_full();
        wait_for_results();

        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_traffic(300, 80, 2);
        wait_for_results();

        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_random_traffic(300, 35, 2);

        sink_stalls = 1'b0;
        test_random_traffic(300, 55, NUM_QUEUES_DEF);
        wait_for_results();

        sender_gaps = 1'b0;
        sink_stalls = 1'b1;
        test_random_traffic(300, 90, 1);

        sender_gaps = 1'b1;
        test_random_traffic(300, 45, 3);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d entered, %0d dropped, %0d served, %0d empty serves.",
                 items_sent, status_seen[ST_ENTERED], status_seen[ST_DROPPED],
                 status_seen[ST_SERVED], status_seen[ST_EMPTY]);
        $display("All rank codes, full levels and ring wrap ran with and without idling.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mqrp_pkg.sv
rtl/mqrp_if.sv
rtl/mqrp_front.sv
rtl/mqrp_cmd_fifo.sv
rtl/mqrp_back.sv
rtl/multi_queue_rank_priority.sv
rtl/mqrp_checker.sv
tb/sv/testbench.sv
